[rtl/gas_sensor_baseline_tracker_macros.svh]
// ----------------------------------------------------------------------------
// Baseline tracker assertion macros
// Shared concurrent assertion forms for the baseline tracker RTL.
// ----------------------------------------------------------------------------
`ifndef GAS_SENSOR_BASELINE_TRACKER_MACROS_SVH
`define GAS_SENSOR_BASELINE_TRACKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GSBT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GSBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/gsbt_pkg.sv]
// ----------------------------------------------------------------------------
// Baseline tracker package
// Request codes, register indexes, reset constants and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package gsbt_pkg;

   typedef enum logic [1:0] {
      REQ_TICK       = 2'd0,
      REQ_CLEAR_BASE = 2'd1,
      REQ_CLEAR_ALL  = 2'd2
   } gsbt_req_type;

   localparam logic [1:0] CSR_DAYS_IN_WINDOW = 2'd0;
   localparam logic [1:0] CSR_TICKS_PER_DAY  = 2'd1;
   localparam logic [1:0] CSR_STARTUP_TICKS  = 2'd2;

   localparam logic [5:0]  DAYS_RESET     = 6'd4;
   localparam logic [13:0] TICKS_RESET    = 14'd10000;
   localparam logic [3:0]  STARTUP_RESET  = 4'd10;
   localparam logic [15:0] BASELINE_CLEAR = 16'd100;
   localparam logic [15:0] PEAK_RESET     = 16'd1;

   localparam int RSP_DATA_W = 88;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } gsbt_state_type;

   typedef struct packed {
      logic shift;
      logic fill;
      logic scan;
   } gsbt_cell_ctl_type;

   typedef struct packed {
      logic        in_startup;
      logic        day_rolled;
      logic [15:0] days_elapsed;
      logic [15:0] window_maximum;
      logic [15:0] day_maximum;
      logic [15:0] clamped_resistance;
      logic [15:0] baseline;
   } gsbt_result_type;

endpackage

`default_nettype wire

[rtl/gsbt_cell.sv]
// ----------------------------------------------------------------------------
// Baseline tracker window cell
// Holds one daily maximum and one running-maximum stage of the window chain.
// ----------------------------------------------------------------------------
`default_nettype none

module gsbt_cell
   import gsbt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gsbt_cell_ctl_type ctl,
   input  wire logic              in_window,
   input  wire logic              at_insert,
   input  wire logic [15:0]       insert_value,
   input  wire logic [15:0]       next_entry,
   input  wire logic [15:0]       next_acc,
   output logic      [15:0]       entry,
   output logic      [15:0]       acc
);

   logic [15:0] entry_ff, entry_in;
   logic [15:0] acc_ff, acc_in;
   logic [15:0] own_value;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.fill) begin
         entry_in = PEAK_RESET;
      end else if (ctl.shift) begin
         if (in_window) begin
            entry_in = next_entry;
         end else if (at_insert) begin
            entry_in = insert_value;
         end
      end
   end

   // cells outside the window contribute nothing to the maximum
   assign own_value = in_window ? entry_ff : 16'd0;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.scan) begin
         acc_in = (own_value > next_acc) ? own_value : next_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= PEAK_RESET;
      end else begin
         entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign entry = entry_ff;
   assign acc   = acc_ff;

endmodule

`default_nettype wire

[rtl/gsbt_window.sv]
// ----------------------------------------------------------------------------
// Baseline tracker daily-maximum window
// Row of cells that shifts in a day maximum and ripples the window maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module gsbt_window
   import gsbt_pkg::*;
#(
   parameter int WINDOW_MAX = 32,
   parameter int SPAN_W     = $clog2(WINDOW_MAX + 1)
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gsbt_cell_ctl_type ctl,
   input  wire logic [SPAN_W-1:0] span,
   input  wire logic [15:0]       insert_value,
   output logic      [15:0]       window_max
);

   logic [15:0] entry_w [0:WINDOW_MAX];
   logic [15:0] acc_w   [0:WINDOW_MAX];

   for (genvar i = 0; i <= WINDOW_MAX; i++) begin : g_cell
      logic        in_window;
      logic        at_insert;
      logic [15:0] next_entry;
      logic [15:0] next_acc;

      assign in_window = {1'b0, span} > (SPAN_W + 1)'(i);
      assign at_insert = span == SPAN_W'(i);

      if (i == WINDOW_MAX) begin : g_top
         assign next_entry = 16'd0;
         assign next_acc   = 16'd0;
      end else begin : g_mid
         // the cell just below the insert slot takes the new day maximum
         assign next_entry = (span == SPAN_W'(i + 1)) ? insert_value : entry_w[i + 1];
         assign next_acc   = acc_w[i + 1];
      end

      gsbt_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .in_window    (in_window),
         .at_insert    (at_insert),
         .insert_value (insert_value),
         .next_entry   (next_entry),
         .next_acc     (next_acc),
         .entry        (entry_w[i]),
         .acc          (acc_w[i])
      );
   end

   assign window_max = acc_w[0];

endmodule

`default_nettype wire

[rtl/gas_sensor_baseline_tracker.sv]
// ----------------------------------------------------------------------------
// Gas sensor baseline tracker
// Tracks a resistance baseline from per-tick samples over a rolling window
// of daily maxima.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one request per beat. req_tuser[1:0] holds the request code
//           (tick with sample, clear baseline, clear all history) and
//           req_tdata[15:0] holds the sample in hundredths.
//   rsp_* : one result per request, packed in rsp_tdata (see port comment).
//   csr_* : register writes; csr_index selects days_in_window (0) or
//           ticks_per_day (1); 2 is ignored. Write only while idle.
// Sequence: a tick that does not end a day and every command post their
//   result to the internal result slot in the cycle after acceptance; it
//   moves on to rsp_tvalid once the output register is free. A tick that
//   ends a day first shifts the row, then ripples the running maximum down
//   the row (ST_SCAN), then finishes (ST_FINISH) and posts its result.
// Throughput: no request is taken until the last result leaves the result
//   slot; req_tready waits for that and stays low through a rollover.
// Stall: a result slot behind the output register lets one more request be
//   taken while rsp_tready is low; then req_tready drops until it drains.
// Reset: synchronous, active high; state and control registers take reset
//   values and every window cell holds one at once, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gas_sensor_baseline_tracker_macros.svh"

module gas_sensor_baseline_tracker
   import gsbt_pkg::*;
#(
   parameter int WINDOW_MAX = 32
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,  // [15:0] resistance
   input  wire logic [1:0]            req_tuser,  // [1:0] req_type
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] baseline, [31:16] clamped_resistance, [47:32] day_maximum,
   // [63:48] window_maximum, [79:64] days_elapsed, [80] day_rolled,
   // [81] in_startup, [87:82] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // configuration channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [13:0]           csr_data
);

   localparam int SPAN_W = $clog2(WINDOW_MAX + 1);
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

   // state and configuration registers
   gsbt_state_type  state_ff, state_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [13:0]     tick_ff, tick_in;
   logic [15:0]     day_count_ff, day_count_in;
   logic [15:0]     day_peak_ff, day_peak_in;
   logic [15:0]     window_peak_ff, window_peak_in;
   logic [15:0]     baseline_ff, baseline_in;
   logic [3:0]      startup_ff, startup_in;
   logic [5:0]      days_in_window_ff;
   logic [13:0]     ticks_per_day_ff;
   logic [15:0]     sample_ff, sample_in;
   gsbt_result_type res_ff, res_in;
   logic            res_valid_ff, res_valid_in;
   gsbt_result_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // request decode
   gsbt_req_type      req_code;
   logic              req_accept;
   logic [14:0]       tick_next;
   logic              roll_due;
   logic [SPAN_W-1:0] span;
   logic [15:0]       window_max;
   gsbt_cell_ctl_type cell_ctl;

   // tick tracking
   logic        do_track;
   logic        emit;
   logic        rolled;
   logic [15:0] track_sample;
   logic [15:0] base_mid;
   logic [15:0] peak_mid;
   logic [3:0]  startup_next;
   logic [15:0] clamped;
   logic        move;

   assign req_code   = gsbt_req_type'(req_tuser);
   assign req_accept = req_tvalid && req_tready;
   assign tick_next  = {1'b0, tick_ff} + 15'd1;
   assign roll_due   = tick_next > {1'b0, ticks_per_day_ff};

   // a window setting above WINDOW_MAX acts as the full row
   assign span = ({1'b0, days_in_window_ff} > 7'(WINDOW_MAX)) ?
                 SPAN_W'(WINDOW_MAX) : SPAN_W'(days_in_window_ff);

   gsbt_window #(
      .WINDOW_MAX (WINDOW_MAX),
      .SPAN_W     (SPAN_W)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .ctl          (cell_ctl),
      .span         (span),
      .insert_value (day_peak_ff),
      .window_max   (window_max)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_code == REQ_TICK && roll_due) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff == CNT_W'(WINDOW_MAX)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE) && !res_valid_ff;
      csr_ready  = 1'b1;
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = RSP_DATA_W'(rsp_ff);
   end

   // datapath
   always_comb begin
      scan_cnt_in    = scan_cnt_ff;
      tick_in        = tick_ff;
      day_count_in   = day_count_ff;
      day_peak_in    = day_peak_ff;
      window_peak_in = window_peak_ff;
      baseline_in    = baseline_ff;
      startup_in     = startup_ff;
      sample_in      = sample_ff;
      cell_ctl       = '0;
      do_track       = 1'b0;
      emit           = 1'b0;
      rolled         = 1'b0;
      track_sample   = req_tdata;
      base_mid       = baseline_ff;
      peak_mid       = day_peak_ff;
      clamped        = 16'd0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_code)
                  REQ_TICK: begin
                     if (roll_due) begin
                        // end the day: shift the row, hold the sample for later
                        tick_in        = 14'd0;
                        day_count_in   = (day_count_ff != 16'hFFFF) ?
                                         day_count_ff + 16'd1 : day_count_ff;
                        cell_ctl.shift = 1'b1;
                        sample_in      = req_tdata;
                        scan_cnt_in    = '0;
                     end else begin
                        tick_in  = tick_next[13:0];
                        do_track = 1'b1;
                     end
                  end
                  REQ_CLEAR_BASE: begin
                     baseline_in = BASELINE_CLEAR;
                     emit        = 1'b1;
                  end
                  REQ_CLEAR_ALL: begin
                     baseline_in    = BASELINE_CLEAR;
                     day_peak_in    = PEAK_RESET;
                     window_peak_in = PEAK_RESET;
                     tick_in        = 14'd0;
                     day_count_in   = 16'd0;
                     cell_ctl.fill  = 1'b1;
                     emit           = 1'b1;
                  end
                  default: begin
                     // unused code: report state, change nothing
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cell_ctl.scan = 1'b1;
            scan_cnt_in   = scan_cnt_ff + CNT_W'(1);
         end
         ST_FINISH: begin
            // window maximum has rippled to the head of the row
            window_peak_in = window_max;
            base_mid       = (day_count_ff > 16'(span)) ? window_max : day_peak_ff;
            peak_mid       = 16'd0;
            track_sample   = sample_ff;
            rolled         = 1'b1;
            do_track       = 1'b1;
         end
         default: begin
         end
      endcase

      // step the startup countdown, then track or clamp the sample
      startup_next = (startup_ff != 4'd0) ? startup_ff - 4'd1 : 4'd0;
      if (do_track) begin
         emit       = 1'b1;
         startup_in = startup_next;
         clamped    = track_sample;
         if (startup_next == 4'd0) begin
            baseline_in = (track_sample > base_mid) ? track_sample : base_mid;
            day_peak_in = (track_sample > peak_mid) ? track_sample : peak_mid;
         end else begin
            baseline_in = base_mid;
            day_peak_in = peak_mid;
            if (track_sample < base_mid) begin
               clamped = base_mid;
            end
         end
      end
   end

   // result slot and output register
   always_comb begin
      move = res_valid_ff && (!rsp_valid_ff || rsp_tready);

      res_in = res_ff;
      if (emit) begin
         res_in.in_startup         = startup_in != 4'd0;
         res_in.day_rolled         = rolled;
         res_in.days_elapsed       = day_count_in;
         res_in.window_maximum     = window_peak_in;
         res_in.day_maximum        = day_peak_in;
         res_in.clamped_resistance = clamped;
         res_in.baseline           = baseline_in;
      end
      res_valid_in = (res_valid_ff && !move) || emit;

      rsp_in       = move ? res_ff : rsp_ff;
      rsp_valid_in = move || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         tick_ff           <= 14'd0;
         day_count_ff      <= 16'd0;
         day_peak_ff       <= PEAK_RESET;
         window_peak_ff    <= PEAK_RESET;
         baseline_ff       <= PEAK_RESET;
         startup_ff        <= STARTUP_RESET;
         days_in_window_ff <= DAYS_RESET;
         ticks_per_day_ff  <= TICKS_RESET;
         res_valid_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tick_ff        <= tick_in;
         day_count_ff   <= day_count_in;
         day_peak_ff    <= day_peak_in;
         window_peak_ff <= window_peak_in;
         baseline_ff    <= baseline_in;
         startup_ff     <= startup_in;
         res_valid_ff   <= res_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         // the startup setting only matters at reset, which restores it anyway
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DAYS_IN_WINDOW: days_in_window_ff <= csr_data[5:0];
               CSR_TICKS_PER_DAY:  ticks_per_day_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff <= scan_cnt_in;
      sample_ff   <= sample_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   `GSBT_ASSERT_NEXT(a_roll_enters_scan, clock, reset, req_accept && req_code == REQ_TICK && roll_due, state_ff == ST_SCAN, "day rollover did not start the window scan")
   `GSBT_ASSERT_IMP(a_finish_slot_free, clock, reset, state_ff == ST_FINISH, !res_valid_ff, "result slot busy when rollover finishes")
   `GSBT_ASSERT_NEXT(a_finish_posts_result, clock, reset, state_ff == ST_FINISH, res_valid_ff && res_ff.day_rolled, "rollover finished without a rolled result")

endmodule

`default_nettype wire
